// File: design/pic_field_gather_1d_defines.svh
// Assertion macros shared by the field gather RTL
`ifndef PIC_FIELD_GATHER_1D_DEFINES_SVH
`define PIC_FIELD_GATHER_1D_DEFINES_SVH
// assert that a implies b on the same edge
`define PFG_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a implies b on the next edge
`define PFG_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// File: design/pfg_pkg.sv
// Package: widths, config indexes and weight helpers for the field gather
`timescale 1ns / 1ps
package pfg_pkg;
    localparam int CELLS_DEF = 1024;
    localparam int NCOMP     = 5;
    localparam int CELL_W    = 10;
    localparam int OFS_W     = 16;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] CFG_ORDER  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_EXT_E1 = 3'd1;
    localparam logic [IDX_W-1:0] CFG_EXT_PR = 3'd2;
    localparam logic [IDX_W-1:0] CFG_EXT_PL = 3'd3;
    localparam logic [IDX_W-1:0] CFG_EXT_SR = 3'd4;
    localparam logic [IDX_W-1:0] CFG_EXT_SL = 3'd5;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [NCOMP*VAL_W-1:0]  t_row;
    typedef logic [32:0]             t_wgt;   // Q1.32 weight, up to 2^32

    typedef struct packed {
        t_wgt wm;
        t_wgt w0;
        t_wgt wp;
    } t_wgts;
endpackage

// File: design/pfg_if.sv
// Valid/ready channel interfaces for gather requests and results
`timescale 1ns / 1ps
interface pfg_req_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [pfg_pkg::CELL_W-1:0]        cell_req;
    logic [pfg_pkg::OFS_W-1:0]         offset;
    logic signed [pfg_pkg::VAL_W-1:0]  in_e1;
    logic signed [pfg_pkg::VAL_W-1:0]  in_pr;
    logic signed [pfg_pkg::VAL_W-1:0]  in_pl;
    logic signed [pfg_pkg::VAL_W-1:0]  in_sr;
    logic signed [pfg_pkg::VAL_W-1:0]  in_sl;
    modport source (output valid, func, cell_req, offset, in_e1, in_pr, in_pl, in_sr,
                    in_sl, input ready);
    modport sink (input valid, func, cell_req, offset, in_e1, in_pr, in_pl, in_sr,
                  in_sl, output ready);
endinterface

interface pfg_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [pfg_pkg::VAL_W-1:0]  out_e1;
    logic signed [pfg_pkg::VAL_W-1:0]  out_pr;
    logic signed [pfg_pkg::VAL_W-1:0]  out_pl;
    logic signed [pfg_pkg::VAL_W-1:0]  out_sr;
    logic signed [pfg_pkg::VAL_W-1:0]  out_sl;
    modport source (output valid, out_e1, out_pr, out_pl, out_sr, out_sl, input ready);
    modport sink (input valid, out_e1, out_pr, out_pl, out_sr, out_sl, output ready);
endinterface

// File: design/pic_field_gather_1d.sv
// Pipeline: an accepted gather word passes grid read with weights, then products,
// then sum, round and saturate into the output register.
// Throughput: one word per cycle; the three-bank grid serves all neighbor reads
// together. Stalls come only from a full output.
// Reset: synchronous active-low; clears control and config (order=1, offsets 0);
// grid contents are undefined until written.
`timescale 1ns / 1ps
`include "pic_field_gather_1d_defines.svh"
module pic_field_gather_1d #(
    parameter int CELLS = pfg_pkg::CELLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfg_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [pfg_pkg::VAL_W-1:0]      i_cfg_data,
    pfg_req_if.sink                        req,
    pfg_res_if.source                      res
);
    localparam int NC = pfg_pkg::NCOMP;
    localparam int VW = pfg_pkg::VAL_W;

    logic                r_order;
    pfg_pkg::t_val       r_ext [NC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b1;
            for (int k = 0; k < NC; k++) r_ext[k] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pfg_pkg::CFG_ORDER:  r_order  <= i_cfg_data[0];
                pfg_pkg::CFG_EXT_E1: r_ext[0] <= i_cfg_data;
                pfg_pkg::CFG_EXT_PR: r_ext[1] <= i_cfg_data;
                pfg_pkg::CFG_EXT_PL: r_ext[2] <= i_cfg_data;
                pfg_pkg::CFG_EXT_SR: r_ext[3] <= i_cfg_data;
                pfg_pkg::CFG_EXT_SL: r_ext[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline: s1 = grid read, s2 = products, s3 = sum/round/sat -> output reg
    logic r_v1, r_v2, r_v3;
    logic adv;
    assign adv = !r_v3 || res.ready;
    assign req.ready = adv;

    logic acc, gat;
    assign acc = req.valid && req.ready;
    assign gat = acc && req.func;

    // write port
    logic we;
    assign we = acc && !req.func && ({7'b0, req.cell_req} < 17'(CELLS));
    pfg_pkg::t_row wdata;
    assign wdata = {req.in_sl, req.in_sr, req.in_pl, req.in_pr, req.in_e1};

    logic [pfg_pkg::CELL_W-1:0] ra_m, ra_p;
    assign ra_m = req.cell_req - 1'b1;
    assign ra_p = req.cell_req + 1'b1;

    pfg_pkg::t_row rd_m, rd_0, rd_p;
    pfg_grid #(.CELLS(CELLS)) u_grid (
        .i_clk(i_clk), .i_we(we), .i_waddr(req.cell_req), .i_wdata(wdata),
        .i_re(gat), .i_raddr_m(ra_m), .i_raddr_0(req.cell_req), .i_raddr_p(ra_p),
        .o_rdata_m(rd_m), .o_rdata_0(rd_0), .o_rdata_p(rd_p)
    );

    pfg_pkg::t_wgts w;
    pfg_weights u_wgt (.i_order(r_order), .i_offset(req.offset), .o_w(w));

    // stage 1 regs
    pfg_pkg::t_wgts r_w1;
    logic r_okm1, r_ok01, r_okp1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= gat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gat) begin
            r_w1   <= w;
            r_okm1 <= req.cell_req != '0 && ({7'b0, ra_m} < 17'(CELLS));
            r_ok01 <= {7'b0, req.cell_req} < 17'(CELLS);
            r_okp1 <= ({7'b0, req.cell_req} + 17'd1) < 17'(CELLS) && ra_p != '0;
        end
    end

    // choose read data, zero out-of-grid neighbors
    pfg_pkg::t_row m_row, z_row, p_row;
    assign m_row = r_okm1 ? rd_m : '0;
    assign z_row = r_ok01 ? rd_0 : '0;
    assign p_row = r_okp1 ? rd_p : '0;

    // stage 2: 15 products of 32-bit signed data by 33-bit unsigned weights
    logic signed [65:0] r_pm [NC];
    logic signed [65:0] r_p0 [NC];
    logic signed [65:0] r_pp [NC];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (adv) r_v2 <= r_v1;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NC; k++) begin
                r_pm[k] <= 66'($signed(m_row[k*VW +: VW]) * $signed({1'b0, r_w1.wm}));
                r_p0[k] <= 66'($signed(z_row[k*VW +: VW]) * $signed({1'b0, r_w1.w0}));
                r_pp[k] <= 66'($signed(p_row[k*VW +: VW]) * $signed({1'b0, r_w1.wp}));
            end
        end
    end

    // stage 3: sum, round, add offset, saturate into output register
    logic signed [67:0] sum [NC];
    logic signed [35:0] rnd [NC];
    logic signed [36:0] tot [NC];
    pfg_pkg::t_val      sat [NC];
    always_comb begin
        for (int k = 0; k < NC; k++) begin
            sum[k] = 68'(r_pm[k]) + 68'(r_p0[k]) + 68'(r_pp[k]) + 68'sh8000_0000;
            rnd[k] = 36'(sum[k] >>> 32);
            tot[k] = 37'(rnd[k]) + 37'(r_ext[k]);
            if (tot[k] > 37'sh0_7FFF_FFFF)       sat[k] = 32'sh7FFF_FFFF;
            else if (tot[k] < -37'sh0_8000_0000) sat[k] = 32'sh8000_0000;
            else                                 sat[k] = tot[k][31:0];
        end
    end

    pfg_pkg::t_val r_out [NC];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (adv) r_v3 <= r_v2;
    end
    always_ff @(posedge i_clk) begin
        if (adv && r_v2) begin
            for (int k = 0; k < NC; k++) r_out[k] <= sat[k];
        end
    end

    assign res.valid  = r_v3;
    assign res.out_e1 = r_out[0];
    assign res.out_pr = r_out[1];
    assign res.out_pl = r_out[2];
    assign res.out_sr = r_out[3];
    assign res.out_sl = r_out[4];

    `PFG_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !r_v3, req.ready)
    `PFG_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, r_v3 && !res.ready, r_v3)
    `PFG_ASSERT_NEXT(a_gather_enters, i_clk, i_rst_n, gat, r_v1)
    `PFG_ASSERT_IMP(a_no_write_on_gather, i_clk, i_rst_n, gat, !we)
endmodule

// File: design/pfg_grid.sv
// Grid store: three replicated banks, one per neighbor read, registered read ports
`timescale 1ns / 1ps
module pfg_grid #(
    parameter int CELLS = pfg_pkg::CELLS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [pfg_pkg::CELL_W-1:0]       i_waddr,
    input  pfg_pkg::t_row                    i_wdata,
    input  logic                             i_re,
    input  logic [pfg_pkg::CELL_W-1:0]       i_raddr_m,
    input  logic [pfg_pkg::CELL_W-1:0]       i_raddr_0,
    input  logic [pfg_pkg::CELL_W-1:0]       i_raddr_p,
    output pfg_pkg::t_row                    o_rdata_m,
    output pfg_pkg::t_row                    o_rdata_0,
    output pfg_pkg::t_row                    o_rdata_p
);
    pfg_pkg::t_row r_bank_m [CELLS];
    pfg_pkg::t_row r_bank_0 [CELLS];
    pfg_pkg::t_row r_bank_p [CELLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_bank_m[i_waddr] <= i_wdata;
            r_bank_0[i_waddr] <= i_wdata;
            r_bank_p[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_m <= r_bank_m[i_raddr_m];
            o_rdata_0 <= r_bank_0[i_raddr_0];
            o_rdata_p <= r_bank_p[i_raddr_p];
        end
    end
endmodule

// File: design/pfg_weights.sv
// Weight generation for linear and quadratic interpolation
`timescale 1ns / 1ps
module pfg_weights (
    input  logic                        i_order,
    input  logic [pfg_pkg::OFS_W-1:0]   i_offset,
    output pfg_pkg::t_wgts              o_w
);
    logic [16:0] ma;
    logic [33:0] sq_m;
    logic [31:0] sq_p;
    logic [16:0] f;

    always_comb begin
        ma   = 17'h10000 - {1'b0, i_offset};
        sq_m = ma * ma;
        sq_p = i_offset * i_offset;
        f    = 17'd0;
        if (i_order) begin
            o_w.wm = sq_m[33:1];
            o_w.wp = {2'b0, sq_p[31:1]};
            o_w.w0 = 33'h1_0000_0000 - o_w.wm - o_w.wp;
        end else if (!i_offset[15]) begin
            f      = {1'b0, i_offset} + 17'h08000;
            o_w.wm = {(17'h10000 - f), 16'h0};
            o_w.w0 = {f, 16'h0};
            o_w.wp = '0;
        end else begin
            f      = {1'b0, i_offset} - 17'h08000;
            o_w.wm = '0;
            o_w.w0 = {(17'h10000 - f), 16'h0};
            o_w.wp = {f, 16'h0};
        end
    end
endmodule

// File: dv/pic_field_gather_1d_tb.sv
// Testbench for the 1-D field gather: grid loads, gathers in both orders, random idling
`timescale 1ns / 1ps
module pic_field_gather_1d_tb;
    localparam int NCELLS = 1024;
    localparam int NC     = pfg_pkg::NCOMP;

    typedef struct {
        logic       func;
        logic [9:0] cidx;
        logic [15:0] ofs;
        logic signed [31:0] v [NC];
    } t_req;

    typedef struct {
        logic signed [31:0] v [NC];
    } t_fld;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [pfg_pkg::IDX_W-1:0] i_cfg_idx = '0;
    logic [pfg_pkg::VAL_W-1:0] i_cfg_data = '0;

    pfg_req_if req();
    pfg_res_if res();

    pic_field_gather_1d #(.CELLS(NCELLS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .req(req), .res(res)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] grid [NCELLS][NC];
    logic               m_order = 1'b1;
    logic signed [31:0] m_ext [NC];
    bit                 loaded_plan [NCELLS];

    t_req  word_q [$];
    t_fld  field_q [$];
    int    errors = 0;
    int    src_idle_pct = 0;
    int    snk_stall_pct = 0;

    function automatic logic signed [63:0] cell_val(int idx, int k);
        if (idx < 0 || idx >= NCELLS) return 0;
        return grid[idx][k];
    endfunction

    function automatic t_fld gather_fields(t_req r);
        t_fld o;
        logic signed [65:0] w [3];
        logic signed [65:0] a, f, s, q;
        int c;
        c = r.cidx;
        a = r.ofs;
        if (m_order) begin
            w[0] = ((66'sd65536 - a) * (66'sd65536 - a)) >>> 1;
            w[2] = (a * a) >>> 1;
            w[1] = (66'sd1 <<< 32) - w[0] - w[2];
        end else if (a < 32768) begin
            f = a + 32768;
            w[0] = (66'sd65536 - f) <<< 16;
            w[1] = f <<< 16;
            w[2] = 0;
        end else begin
            f = a - 32768;
            w[0] = 0;
            w[1] = (66'sd65536 - f) <<< 16;
            w[2] = f <<< 16;
        end
        for (int k = 0; k < NC; k++) begin
            s = 0;
            for (int j = 0; j < 3; j++) s += cell_val(c - 1 + j, k) * w[j];
            q = ((s + (66'sd1 <<< 31)) >>> 32) + m_ext[k];
            if (q > 66'sd2147483647) q = 66'sd2147483647;
            if (q < -66'sd2147483648) q = -66'sd2147483648;
            o.v[k] = q[31:0];
        end
        return o;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req.valid <= 1'b0;
        end else if (!req.valid || req.ready) begin
            if (word_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                t_req r;
                r = word_q.pop_front();
                req.valid <= 1'b1;
                req.func <= r.func;
                req.cell_req <= r.cidx;
                req.offset <= r.ofs;
                req.in_e1 <= r.v[0];
                req.in_pr <= r.v[1];
                req.in_pl <= r.v[2];
                req.in_sr <= r.v[3];
                req.in_sl <= r.v[4];
            end else begin
                req.valid <= 1'b0;
            end
        end
    end

    // track accepted words
    always @(posedge i_clk) begin
        if (i_rst_n && req.valid && req.ready) begin
            t_req r;
            r.func = req.func;
            r.cidx = req.cell_req;
            r.ofs = req.offset;
            r.v[0] = req.in_e1; r.v[1] = req.in_pr; r.v[2] = req.in_pl;
            r.v[3] = req.in_sr; r.v[4] = req.in_sl;
            if (r.func) begin
                field_q.push_back(gather_fields(r));
            end else if (r.cidx < NCELLS) begin
                for (int k = 0; k < NC; k++) grid[r.cidx][k] = r.v[k];
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                logic signed [31:0] got [NC];
                got[0] = res.out_e1; got[1] = res.out_pr; got[2] = res.out_pl;
                got[3] = res.out_sr; got[4] = res.out_sl;
                if (field_q.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    t_fld e;
                    e = field_q.pop_front();
                    for (int k = 0; k < NC; k++)
                        if (got[k] !== e.v[k]) begin
                            $error("%s expected %0d got %0d",
                                   k == 0 ? "out_e1" : k == 1 ? "out_pr" :
                                   k == 2 ? "out_pl" : k == 3 ? "out_sr" : "out_sl",
                                   e.v[k], got[k]);
                            errors++;
                        end
                end
            end
            res.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic wait_drained();
        while (word_q.size() > 0 || req.valid || field_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [pfg_pkg::IDX_W-1:0] idx, logic [31:0] d);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pfg_pkg::CFG_ORDER) m_order = d[0];
        else m_ext[idx - 1] = d;
    endtask

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(131072)) - 65536;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_cell(int c, logic signed [31:0] val);
        t_req r;
        r.func = 1'b0; r.cidx = 10'(c); r.ofs = 16'($urandom);
        for (int k = 0; k < NC; k++) r.v[k] = (val === 'x) ? rand_val() : val;
        word_q.push_back(r);
    endtask

    task automatic add_gather(int c, int ofs);
        t_req r;
        r.func = 1'b1; r.cidx = 10'(c); r.ofs = 16'(ofs);
        for (int k = 0; k < NC; k++) r.v[k] = $urandom;
        word_q.push_back(r);
    endtask

    // gather only where all in-grid neighbors are loaded
    function automatic bit safe_cell(int c);
        for (int j = c - 1; j <= c + 1; j++)
            if (j >= 0 && j < NCELLS && !loaded_plan[j]) return 0;
        return 1;
    endfunction

    task automatic random_phase(int n);
        int c;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 30) begin
                c = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(15);
                load_cell(c, 'x);
                loaded_plan[c] = 1;
            end else begin
                do c = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(15);
                while (!safe_cell(c));
                add_gather(c, $urandom_range(3) == 0 ? ($urandom_range(1) ? 0 : 65535)
                                                      : $urandom_range(65535));
            end
        end
    endtask

    initial begin
        for (int k = 0; k < NC; k++) m_ext[k] = 0;
        req.valid = 1'b0; req.func = 1'b0; req.cell_req = '0; req.offset = '0;
        req.in_e1 = '0; req.in_pr = '0; req.in_pl = '0; req.in_sr = '0; req.in_sl = '0;
        res.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edges of grid, extremes of values and offsets
        foreach (loaded_plan[i]) loaded_plan[i] = 0;
        for (int c = 0; c < 16; c++) begin
            load_cell(c, c == 1 ? 32'sh7fffffff : c == 2 ? 32'sh80000000 : 'x);
            loaded_plan[c] = 1;
        end
        for (int c = 1020; c < 1024; c++) begin
            load_cell(c, c == 1023 ? 32'sh7fffffff : 'x);
            loaded_plan[c] = 1;
        end
        add_gather(0, 0);
        add_gather(1, 65535);
        add_gather(2, 32768);
        add_gather(1023, 65535);
        add_gather(5, 32767);
        wait_drained();
        write_reg(pfg_pkg::CFG_ORDER, 32'd0);
        add_gather(0, 0);
        add_gather(1023, 65535);
        add_gather(2, 32767);
        add_gather(3, 32768);
        wait_drained();

        // extremes of offsets force saturation both ways
        write_reg(pfg_pkg::CFG_EXT_E1, 32'h7fffffff);
        write_reg(pfg_pkg::CFG_EXT_PR, 32'h80000000);
        write_reg(pfg_pkg::CFG_EXT_PL, 32'h00010000);
        write_reg(pfg_pkg::CFG_EXT_SR, $urandom);
        write_reg(pfg_pkg::CFG_EXT_SL, 32'hffff0000);
        random_phase(100);
        wait_drained();

        write_reg(pfg_pkg::CFG_ORDER, 32'd1);
        src_idle_pct = 88;
        random_phase(90);
        wait_drained();

        write_reg(pfg_pkg::CFG_EXT_E1, 32'd0);
        write_reg(pfg_pkg::CFG_EXT_PR, 32'd0);
        write_reg(pfg_pkg::CFG_EXT_PL, 32'd0);
        write_reg(pfg_pkg::CFG_EXT_SR, 32'd0);
        write_reg(pfg_pkg::CFG_EXT_SL, 32'd0);
        src_idle_pct = 0; snk_stall_pct = 88;
        random_phase(90);
        wait_drained();

        write_reg(pfg_pkg::CFG_ORDER, 32'd0);
        write_reg(pfg_pkg::CFG_EXT_SR, 32'h80000000);
        src_idle_pct = 10; snk_stall_pct = 10;
        random_phase(140);
        wait_drained();

        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end
endmodule
